[src/pat_pkg.sv]
`timescale 1ns / 1ps

package pat_pkg;

	// Result status codes
	localparam logic [1:0] STATUS_HIT  = 2'd0;
	localparam logic [1:0] STATUS_NEW  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// Direction codes
	localparam logic DIR_RX = 1'b0;
	localparam logic DIR_TX = 1'b1;

	// Field widths
	localparam int ADDR_W   = 32;
	localparam int AMOUNT_W = 32;
	localparam int TOTAL_W  = 64;
	localparam int INDEX_W  = 4;

	// Packet and byte counter pair of one direction of one entry
	typedef struct packed {
		logic [TOTAL_W-1:0] bytes;
		logic [TOTAL_W-1:0] pkts;
	} ctr_pair_t;

	// Write port of a counter memory
	typedef struct packed {
		logic      en;
		ctr_pair_t data;
	} ctr_wr_t;

endpackage

[src/pat_ctr_mem.sv]
`timescale 1ns / 1ps

// Counter memory of one direction: one write and one registered read per cycle.
// The last write is kept aside so that a read taken in the same cycle as a
// write to the same entry still returns the new value.
module pat_ctr_mem #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output pat_pkg::ctr_pair_t         rd_data,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  pat_pkg::ctr_wr_t           wr
);

	localparam int AW = $clog2(ENTRIES);

	pat_pkg::ctr_pair_t mem [ENTRIES];
	pat_pkg::ctr_pair_t rd_q;
	logic [AW-1:0]      rd_addr_q;
	logic               byp_v_q;
	logic [AW-1:0]      byp_addr_q;
	pat_pkg::ctr_pair_t byp_data_q;

	// Write the entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	// Read the entry into the output register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Hold the most recent write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= 1'b0;
		end else if (wr.en) begin
			byp_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			byp_addr_q <= wr_addr;
			byp_data_q <= wr.data;
		end
	end

	// Prefer the held write when it hit the entry that was read
	assign rd_data = (byp_v_q && byp_addr_q == rd_addr_q) ? byp_data_q : rd_q;

endmodule

[src/per_address_traffic_counters_top.sv]
`timescale 1ns / 1ps

// Per-address traffic counters. Each input item carries an IPv4 address, a
// direction in tuser (0 receive, 1 transmit) and packet and byte amounts; the
// block looks the address up in a table of TABLE_ENTRIES entries, claims the
// lowest free entry on a miss, adds the amounts to that direction's 64-bit
// counters (which wrap) and returns one result item with the status in tuser
// (0 updated, 1 new entry, 2 table full and dropped) and the entry index and
// updated totals in tdata. The table is empty after reset and entries are
// never released. It takes one item every cycle unless m_tready holds the
// result back, passing it through the stage 1, stage 2 and result registers;
// the address match and entry claim are done together in stage 1, and each
// direction's counters sit in a memory with one read and one write per cycle.
module per_address_traffic_counters_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata: ip_addr[31:0], packet_count[63:32], byte_count[95:64]
	input  logic [95:0]  s_tdata,
	// s_tuser: func[0]
	input  logic         s_tuser,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m_tdata: entry_index[3:0], packet_total[67:4], byte_total[131:68], zeros above
	output logic [135:0] m_tdata,
	// m_tuser: status[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tvalid,
	input  logic         m_tready
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// Table of addresses
	logic [TABLE_ENTRIES-1:0]      valid_q;
	logic [pat_pkg::ADDR_W-1:0]    addr_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]              entries_used_q;

	// Stage 1
	logic                          v_s1;
	logic [pat_pkg::ADDR_W-1:0]    ip_s1;
	logic                          dir_s1;
	logic [pat_pkg::AMOUNT_W-1:0]  pkt_s1;
	logic [pat_pkg::AMOUNT_W-1:0]  byte_s1;

	// Stage 2
	logic                          v_s2;
	logic [1:0]                    status_s2;
	logic [IDX_W-1:0]              slot_s2;
	logic                          dir_s2;
	logic [pat_pkg::AMOUNT_W-1:0]  pkt_s2;
	logic [pat_pkg::AMOUNT_W-1:0]  byte_s2;

	// Result register
	logic                          out_v_q;
	logic [1:0]                    status_q;
	logic [pat_pkg::INDEX_W-1:0]   index_q;
	logic [pat_pkg::TOTAL_W-1:0]   ptot_q;
	logic [pat_pkg::TOTAL_W-1:0]   btot_q;

	logic                          out_en;
	logic                          s2_adv;
	logic                          s2_load_ok;
	logic                          s1_adv;

	logic                          hit;
	logic [IDX_W-1:0]              hit_idx;
	logic                          full;
	logic [IDX_W-1:0]              slot_s1;
	logic [1:0]                    status_s1;
	logic                          claim;

	pat_pkg::ctr_pair_t            rx_rd;
	pat_pkg::ctr_pair_t            tx_rd;
	pat_pkg::ctr_pair_t            base;
	pat_pkg::ctr_pair_t            sum;
	pat_pkg::ctr_wr_t              rx_wr;
	pat_pkg::ctr_wr_t              tx_wr;
	logic                          upd_s2;
	logic [IDX_W+pat_pkg::INDEX_W-1:0] slot_ext;

	// Advance the stages where the next one has room
	assign out_en     = !out_v_q || m_tready;
	assign s2_adv     = v_s2 && out_en;
	assign s2_load_ok = !v_s2 || out_en;
	assign s1_adv     = v_s1 && s2_load_ok;
	assign s_tready   = !v_s1 || s2_load_ok;

	// Stage 1 input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ip_s1   <= s_tdata[31:0];
			pkt_s1  <= s_tdata[63:32];
			byte_s1 <= s_tdata[95:64];
			dir_s1  <= s_tuser;
		end
	end

	// Match the address against all valid entries
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_q[i] && addr_q[i] == ip_s1) begin
				hit     = 1'b1;
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	// Entries fill from the bottom, so the lowest free one is the fill count
	assign full = (entries_used_q == CNT_W'(TABLE_ENTRIES));

	always_comb begin
		priority if (hit) begin
			status_s1 = pat_pkg::STATUS_HIT;
			slot_s1   = hit_idx;
		end else if (full) begin
			status_s1 = pat_pkg::STATUS_FULL;
			slot_s1   = '0;
		end else begin
			status_s1 = pat_pkg::STATUS_NEW;
			slot_s1   = entries_used_q[IDX_W-1:0];
		end
	end

	assign claim = s1_adv && status_s1 == pat_pkg::STATUS_NEW;

	// Claim a free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			entries_used_q <= '0;
		end else if (claim) begin
			valid_q[slot_s1] <= 1'b1;
			entries_used_q   <= entries_used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			addr_q[slot_s1] <= ip_s1;
		end
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_load_ok) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_s2 <= status_s1;
			slot_s2   <= slot_s1;
			dir_s2    <= dir_s1;
			pkt_s2    <= pkt_s1;
			byte_s2   <= byte_s1;
		end
	end

	// Counter memories, one per direction
	pat_ctr_mem #(
		.ENTRIES(TABLE_ENTRIES)
	) u_rx_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s1_adv),
		.rd_addr (slot_s1),
		.rd_data (rx_rd),
		.wr_addr (slot_s2),
		.wr      (rx_wr)
	);

	pat_ctr_mem #(
		.ENTRIES(TABLE_ENTRIES)
	) u_tx_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s1_adv),
		.rd_addr (slot_s1),
		.rd_data (tx_rd),
		.wr_addr (slot_s2),
		.wr      (tx_wr)
	);

	// Add the amounts; a new entry starts from zero
	always_comb begin
		if (status_s2 == pat_pkg::STATUS_NEW) begin
			base = '0;
		end else if (dir_s2 == pat_pkg::DIR_TX) begin
			base = tx_rd;
		end else begin
			base = rx_rd;
		end
		sum.pkts  = base.pkts + {{(pat_pkg::TOTAL_W-pat_pkg::AMOUNT_W){1'b0}}, pkt_s2};
		sum.bytes = base.bytes + {{(pat_pkg::TOTAL_W-pat_pkg::AMOUNT_W){1'b0}}, byte_s2};
	end

	// Write the sum back; on a claim clear the other direction too
	assign upd_s2 = s2_adv && status_s2 != pat_pkg::STATUS_FULL;

	always_comb begin
		rx_wr.en   = upd_s2 && (dir_s2 == pat_pkg::DIR_RX || status_s2 == pat_pkg::STATUS_NEW);
		rx_wr.data = (dir_s2 == pat_pkg::DIR_RX) ? sum : '0;
		tx_wr.en   = upd_s2 && (dir_s2 == pat_pkg::DIR_TX || status_s2 == pat_pkg::STATUS_NEW);
		tx_wr.data = (dir_s2 == pat_pkg::DIR_TX) ? sum : '0;
	end

	assign slot_ext = {{pat_pkg::INDEX_W{1'b0}}, slot_s2};

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			status_q <= status_s2;
			if (status_s2 == pat_pkg::STATUS_FULL) begin
				index_q <= '0;
				ptot_q  <= '0;
				btot_q  <= '0;
			end else begin
				index_q <= slot_ext[pat_pkg::INDEX_W-1:0];
				ptot_q  <= sum.pkts;
				btot_q  <= sum.bytes;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {4'b0000, btot_q, ptot_q, index_q};

endmodule

[src/pat_checker.sv]
`timescale 1ns / 1ps

// Port-level checks of the traffic counters
module pat_checker (
	input logic         clk,
	input logic         arst_n,
	input logic [135:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tvalid,
	input logic         m_tready
);

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only the three status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == pat_pkg::STATUS_HIT || m_tuser == pat_pkg::STATUS_NEW ||
			m_tuser == pat_pkg::STATUS_FULL))
		else $error("bad status code");

	// A dropped update reports no index and no totals
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pat_pkg::STATUS_FULL |-> m_tdata == '0)
		else $error("dropped update carries data");

endmodule

bind per_address_traffic_counters_top pat_checker u_pat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
